[src/jtelc_pkg.sv]
// Shared constants and types of the jump-row escape-or-loop checker.
package jtelc_pkg;

  localparam int unsigned MaxCells  = 1024;
  localparam int unsigned DistBits  = 20;
  localparam int unsigned AddrW     = $clog2(MaxCells);
  localparam int unsigned CntW      = AddrW + 1;
  localparam int unsigned SumW      = ((DistBits > CntW) ? DistBits : CntW) + 1;
  localparam int unsigned InDataW   = ((1 + DistBits + 7) / 8) * 8;
  localparam int unsigned OutDataW  = 8;
  localparam int unsigned VerdictW  = 2;

  typedef enum logic [VerdictW-1:0] {
    VerdictEscape  = 2'd0,
    VerdictLoop    = 2'd1,
    VerdictTooLong = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    StLoad,
    StStart,
    StWalk,
    StFinish
  } state_e;

  typedef struct packed {
    logic                go_left;
    logic [DistBits-1:0] distance;
  } cell_t;

endpackage

[src/jump_table_escape_or_loop_check.sv]
// Top level of the jump-row escape-or-loop checker: loader, walker and result register.
//
// Cells stream in one request per cycle while the loader is ready and are written into
// a 1024-entry cell memory (direction and jump distance) together with a cleared
// visited bit in a second 1024-entry memory. The request that carries tlast ends the
// row; if more than 1024 cells arrived, the verdict is "row too long" at once.
// Otherwise the walker starts at cell 0: a start state issues the first read, then
// every cycle consumes one registered read of the cell and visited memories, marks the
// cell visited, and issues the read of the next cell. The verdict is then handed to the
// result register once it is free. No input is taken while a walk runs or a verdict
// waits for the hand-off. Visited bits are cleared as cells load, so no clearing pass
// is needed after reset or between rows. The result register holds a verdict until it
// is taken, while the next row loads.
module jump_table_escape_or_loop_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: [0] go_left, [20:1] distance, upper bits zero
  input  logic [jtelc_pkg::InDataW-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,   // last_cell
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: [1:0] verdict, upper bits zero
  output logic [jtelc_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);

  localparam int unsigned AddrW    = jtelc_pkg::AddrW;
  localparam int unsigned CntW     = jtelc_pkg::CntW;
  localparam int unsigned SumW     = jtelc_pkg::SumW;
  localparam int unsigned DistBits = jtelc_pkg::DistBits;
  localparam int unsigned MaxCells = jtelc_pkg::MaxCells;

  // Memories
  jtelc_pkg::cell_t cell_mem [MaxCells];
  logic             vis_mem  [MaxCells];

  jtelc_pkg::cell_t cell_rdata_q;
  logic             vis_rdata_q;
  logic             cell_we;
  logic             vis_we;
  logic             vis_wdata;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  jtelc_pkg::cell_t cell_wdata;

  // Control state
  jtelc_pkg::state_e   state_q, state_d;
  logic [CntW-1:0]     cell_count_q, cell_count_d;
  logic                overflowed_q, overflowed_d;
  logic [AddrW-1:0]    pos_q, pos_d;
  logic                hit_q, hit_d;
  jtelc_pkg::verdict_e verdict_q, verdict_d;
  logic                out_valid_q, out_valid_d;
  jtelc_pkg::verdict_e out_verdict_q, out_verdict_d;

  // Walk datapath
  logic              visited;
  logic [SumW-1:0]   pos_ext;
  logic [SumW-1:0]   dist_ext;
  logic [SumW-1:0]   count_ext;
  logic [SumW-1:0]   right_sum;
  logic [SumW-1:0]   left_diff;
  logic              escapes;
  logic [AddrW-1:0]  next_pos;

  assign cell_wdata.go_left  = s_axis_tdata[0];
  assign cell_wdata.distance = s_axis_tdata[DistBits:1];

  // A write and a read of the same entry in one cycle return the old value:
  // hit_q marks that the entry now being read was just marked visited.
  assign visited   = vis_rdata_q | hit_q;
  assign pos_ext   = SumW'(pos_q);
  assign dist_ext  = SumW'(cell_rdata_q.distance);
  assign count_ext = SumW'(cell_count_q);
  assign right_sum = pos_ext + dist_ext;
  assign left_diff = pos_ext - dist_ext;

  always_comb begin
    if (cell_rdata_q.go_left) begin
      escapes  = (dist_ext > pos_ext);
      next_pos = left_diff[AddrW-1:0];
    end else begin
      escapes  = (right_sum >= count_ext);
      next_pos = right_sum[AddrW-1:0];
    end
  end

  always_comb begin
    state_d       = state_q;
    cell_count_d  = cell_count_q;
    overflowed_d  = overflowed_q;
    pos_d         = pos_q;
    hit_d         = 1'b0;
    verdict_d     = verdict_q;
    out_valid_d   = out_valid_q;
    out_verdict_d = out_verdict_q;
    cell_we       = 1'b0;
    vis_we        = 1'b0;
    vis_wdata     = 1'b0;
    wr_addr       = cell_count_q[AddrW-1:0];
    rd_addr       = pos_q;
    s_axis_tready = (state_q == jtelc_pkg::StLoad);

    // Drop the held verdict once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      jtelc_pkg::StLoad: begin
        if (s_axis_tvalid) begin
          if (cell_count_q < CntW'(MaxCells)) begin
            // Store the cell and clear its visited bit for this row
            cell_we      = 1'b1;
            vis_we       = 1'b1;
            vis_wdata    = 1'b0;
            cell_count_d = cell_count_q + CntW'(1);
          end else begin
            overflowed_d = 1'b1;
          end
          if (s_axis_tlast) begin
            if (overflowed_d) begin
              verdict_d    = jtelc_pkg::VerdictTooLong;
              cell_count_d = '0;
              overflowed_d = 1'b0;
              state_d      = jtelc_pkg::StFinish;
            end else begin
              state_d = jtelc_pkg::StStart;
            end
          end
        end
      end
      jtelc_pkg::StStart: begin
        // Issue the read of cell 0 once its write has landed
        rd_addr = '0;
        pos_d   = '0;
        state_d = jtelc_pkg::StWalk;
      end
      jtelc_pkg::StWalk: begin
        if (visited) begin
          verdict_d    = jtelc_pkg::VerdictLoop;
          cell_count_d = '0;
          state_d      = jtelc_pkg::StFinish;
        end else begin
          vis_we    = 1'b1;
          vis_wdata = 1'b1;
          wr_addr   = pos_q;
          if (escapes) begin
            verdict_d    = jtelc_pkg::VerdictEscape;
            cell_count_d = '0;
            state_d      = jtelc_pkg::StFinish;
          end else begin
            rd_addr = next_pos;
            pos_d   = next_pos;
            hit_d   = (next_pos == pos_q);
          end
        end
      end
      jtelc_pkg::StFinish: begin
        // Hand over once the result register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d   = 1'b1;
          out_verdict_d = verdict_q;
          state_d       = jtelc_pkg::StLoad;
        end
      end
      default: begin
        state_d = jtelc_pkg::StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= jtelc_pkg::StLoad;
      cell_count_q <= '0;
      overflowed_q <= 1'b0;
      pos_q        <= '0;
      hit_q        <= 1'b0;
      verdict_q    <= jtelc_pkg::VerdictEscape;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cell_count_q <= cell_count_d;
      overflowed_q <= overflowed_d;
      pos_q        <= pos_d;
      hit_q        <= hit_d;
      verdict_q    <= verdict_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_verdict_q <= out_verdict_d;
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[wr_addr] <= cell_wdata;
    end
    cell_rdata_q <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[wr_addr] <= vis_wdata;
    end
    vis_rdata_q <= vis_mem[rd_addr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(jtelc_pkg::OutDataW - jtelc_pkg::VerdictW){1'b0}}, out_verdict_q};

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_count_q <= CntW'(MaxCells))
    else $error("cell count beyond store depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflowed_q |-> (cell_count_q == CntW'(MaxCells)))
    else $error("overflow flagged with store not full");

  a_walk_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jtelc_pkg::StWalk) |-> (CntW'(pos_q) < cell_count_q))
    else $error("walk position outside loaded row");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jtelc_pkg::StStart) |-> (cell_count_q != '0))
    else $error("walk started on an empty row");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_verdict_q == jtelc_pkg::VerdictEscape ||
                     out_verdict_q == jtelc_pkg::VerdictLoop ||
                     out_verdict_q == jtelc_pkg::VerdictTooLong))
    else $error("invalid verdict presented");

endmodule

[test/row_verdict_checker.sv]
// Checker for the jump-row checker: predicts each row's verdict and compares it with the output.
module row_verdict_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [jtelc_pkg::InDataW-1:0]  s_axis_tdata,  // [0] go_left, [20:1] distance
  input  logic                           s_axis_tlast,  // last_cell
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [jtelc_pkg::OutDataW-1:0] m_axis_tdata,  // [1:0] verdict
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output int unsigned                    mismatches_o,
  output int unsigned                    verdicts_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                           row_left [jtelc_pkg::MaxCells];
  logic [jtelc_pkg::DistBits-1:0] row_dist [jtelc_pkg::MaxCells];
  int unsigned                    row_len      = 0;
  bit                             row_overflow = 1'b0;
  jtelc_pkg::verdict_e            verdicts_due [$];
  int unsigned                    mismatches   = 0;
  int unsigned                    pending      = 0;
  logic [jtelc_pkg::VerdictW-1:0] got_verdict;
  jtelc_pkg::verdict_e            want_verdict;
  jtelc_pkg::verdict_e            due_verdict;

  assign mismatches_o       = mismatches;
  assign verdicts_pending_o = pending;

  // Walk the loaded row from cell 0 with a fresh visited map.
  function automatic jtelc_pkg::verdict_e walk_verdict();
    bit     seen [jtelc_pkg::MaxCells];
    longint pos;
    longint step;
    foreach (seen[i]) seen[i] = 1'b0;
    pos = 0;
    while (1'b1) begin
      if (pos >= row_len) return jtelc_pkg::VerdictEscape;
      if (seen[pos]) return jtelc_pkg::VerdictLoop;
      seen[pos] = 1'b1;
      step = row_dist[pos];
      if (row_left[pos]) begin
        if (step > pos) return jtelc_pkg::VerdictEscape;
        pos = pos - step;
      end else begin
        if (pos + step >= row_len) return jtelc_pkg::VerdictEscape;
        pos = pos + step;
      end
    end
    return jtelc_pkg::VerdictEscape;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len      = 0;
      row_overflow = 1'b0;
      verdicts_due.delete();
      pending      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_verdict = m_axis_tdata[jtelc_pkg::VerdictW-1:0];
        if (verdicts_due.size() == 0) begin
          mismatches++;
          $display("%0t: verdict: expected none, actual %0d", $time, got_verdict);
        end else begin
          want_verdict = verdicts_due.pop_front();
          if (got_verdict !== want_verdict) begin
            mismatches++;
            $display("%0t: verdict: expected %0d, actual %0d", $time, want_verdict,
                     got_verdict);
          end
          if (m_axis_tdata[jtelc_pkg::OutDataW-1:jtelc_pkg::VerdictW] !== '0) begin
            mismatches++;
            $display("%0t: padding: expected 0, actual %0h", $time,
                     m_axis_tdata[jtelc_pkg::OutDataW-1:jtelc_pkg::VerdictW]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        // drop cells beyond the store and remember the row as too long
        if (row_len < jtelc_pkg::MaxCells) begin
          row_left[row_len] = s_axis_tdata[0];
          row_dist[row_len] = s_axis_tdata[jtelc_pkg::DistBits:1];
          row_len++;
        end else begin
          row_overflow = 1'b1;
        end
        if (s_axis_tlast) begin
          due_verdict  = row_overflow ? jtelc_pkg::VerdictTooLong : walk_verdict();
          verdicts_due = {verdicts_due, due_verdict};
          row_len      = 0;
          row_overflow = 1'b0;
        end
      end
      pending = verdicts_due.size();
    end
  end

endmodule

[test/jump_table_escape_or_loop_check_test.sv]
// Testbench top for the jump-row escape-or-loop checker: stimulus, idling and verdict.
module jump_table_escape_or_loop_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Worst case is a few thousand cells at heavy idling plus full-length walks,
  // far below this limit, so this limit only catches a hang.
  localparam int unsigned CycleLimit  = 400_000;
  // Covers the longest walk plus the hand-off to the result register.
  localparam int unsigned DrainCycles = 1100;
  localparam int unsigned ItemsPerPhase = 175;
  localparam logic [jtelc_pkg::DistBits-1:0] MaxDist = '1;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic [jtelc_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                           s_axis_tlast  = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [jtelc_pkg::OutDataW-1:0] m_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;

  int unsigned mismatches;
  int unsigned verdicts_pending;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;   // chance per cycle that the sender holds back
  int unsigned stall_pct   = 0;   // chance per cycle that the receiver stalls
  int unsigned cells_sent  = 0;
  jtelc_pkg::cell_t row_q [$];    // row being assembled before it is sent

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  jump_table_escape_or_loop_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  row_verdict_checker verdict_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tlast       (s_axis_tlast),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .mismatches_o       (mismatches),
    .verdicts_pending_o (verdicts_pending)
  );

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Receiver: stall at random at the current phase's rate.
  always @(posedge clk_i) begin
    m_axis_tready <= !chance(stall_pct);
  end

  // Watchdog: give up on a hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one cell request and hold it until the block takes it. Entered at a rising
  // edge; valid is written once per edge, so a back-to-back request never dips.
  task automatic send_cell(input logic left, input logic [jtelc_pkg::DistBits-1:0] jump_len,
                           input logic last);
    while (chance(idle_pct)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= jtelc_pkg::InDataW'({jump_len, left});
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    cells_sent++;
  endtask

  // Send the assembled row, flagging its final cell.
  task automatic send_row();
    int unsigned n;
    n = row_q.size();
    for (int unsigned k = 0; k < n; k++) begin
      send_cell(row_q[k].go_left, row_q[k].distance, k == n - 1);
    end
    row_q.delete();
  endtask

  task automatic add_cell(input logic left, input int unsigned jump_len);
    jtelc_pkg::cell_t fresh;
    fresh.go_left  = left;
    fresh.distance = jtelc_pkg::DistBits'(jump_len);
    row_q = {row_q, fresh};
  endtask

  // Build a row with random content. Most jumps are no longer than the row so walks run
  // long and close loops; the rest land exactly on an end, step just past it, or
  // use wide distances that exercise every distance bit.
  task automatic random_row();
    int unsigned len;
    int unsigned pick;
    int unsigned reach;
    logic        left;
    logic [jtelc_pkg::DistBits-1:0] jump_len;
    pick = $urandom_range(99);
    if (pick < 65) len = $urandom_range(8, 1);
    else if (pick < 96) len = $urandom_range(40, 9);
    else len = $urandom_range(300, 100);
    for (int unsigned i = 0; i < len; i++) begin
      left = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 70) begin
        jump_len = jtelc_pkg::DistBits'($urandom_range(len, 1));
      end else if (pick < 80) begin
        reach    = left ? i : len - 1 - i;
        jump_len = jtelc_pkg::DistBits'((reach == 0) ? 1 : reach);
      end else if (pick < 85) begin
        jump_len = jtelc_pkg::DistBits'(left ? i + 1 : len - i);
      end else if (pick < 95) begin
        jump_len = jtelc_pkg::DistBits'($urandom_range(MaxDist, 1));
      end else begin
        jump_len = MaxDist;
      end
      add_cell(left, jump_len);
    end
    send_row();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows, no idling.
    // single cells: step right off the row, left off the row, onto itself
    add_cell(1'b0, 1);
    send_row();
    add_cell(1'b1, 1);
    send_row();
    add_cell(1'b0, 0);
    send_row();
    // widest distances in both directions
    add_cell(1'b0, MaxDist);
    send_row();
    add_cell(1'b1, MaxDist);
    send_row();
    // two cells bouncing between each other, then two stepping off the end
    add_cell(1'b0, 1);
    add_cell(1'b1, 1);
    send_row();
    add_cell(1'b0, 1);
    add_cell(1'b0, 1);
    send_row();
    // three cells: a loop back to cell 0, then a jump past the end
    add_cell(1'b0, 2);
    add_cell(1'b1, 1);
    add_cell(1'b1, 1);
    send_row();
    add_cell(1'b0, 2);
    add_cell(1'b1, 1);
    add_cell(1'b0, 5);
    send_row();
    // full store: walk every cell, then jump from the last one back to cell 0
    repeat (jtelc_pkg::MaxCells - 1) add_cell(1'b0, 1);
    add_cell(1'b1, jtelc_pkg::MaxCells - 1);
    send_row();
    // one cell more than the store holds, with the last cell the dropped one
    repeat (jtelc_pkg::MaxCells + 1) add_cell(1'b0, 1);
    send_row();
    // the row after a too-long one must start clean: a loop, then an escape
    add_cell(1'b0, 1);
    add_cell(1'b1, 1);
    send_row();
    add_cell(1'b0, 1);
    add_cell(1'b0, 1);
    send_row();

    // Random rows through the idling phases: none, sender, receiver, both.
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      reach_target : begin
        int unsigned target;
        target = cells_sent + ItemsPerPhase;
        while (cells_sent < target) random_row();
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    // Drain: let the checker see the last request, wait for every verdict, then
    // allow a full walk's worth of cycles for anything spurious.
    @(posedge clk_i);
    while (verdicts_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && verdicts_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
